### rtl/sstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-first disk scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

   // default geometry
   localparam int DEF_NUM_REQUESTS  = 8;
   localparam int DEF_NUM_CYLINDERS = 4096;

   // fixed field widths
   localparam int CYL_W   = 12;
   localparam int SLOT_W  = 3;
   localparam int DIST_W  = 12;
   localparam int TOTAL_W = 16;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // stream packing
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   // command codes carried on req_tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   // selector control from the sequencer
   typedef struct packed {
      logic clear;    // forget the current best candidate
      logic sample;   // read data for one slot is on the store output
   } sel_ctrl_type;

endpackage

### rtl/sstf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_store
// Request store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_store
   import sstf_pkg::*;
#(
   parameter int NUM_REQUESTS = DEF_NUM_REQUESTS,
   localparam int AW = (NUM_REQUESTS > 1) ? $clog2(NUM_REQUESTS) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [CYL_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [CYL_W-1:0] rd_data
);

   logic [CYL_W-1:0] mem_ff [NUM_REQUESTS];
   logic [CYL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sstf_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_select
// Nearest-request tracker: compares one slot per cycle against the head, when sample is set.
// ----------------------------------------------------------------------------
module sstf_select
   import sstf_pkg::*;
#(
   parameter int NUM_REQUESTS = DEF_NUM_REQUESTS,
   localparam int AW = (NUM_REQUESTS > 1) ? $clog2(NUM_REQUESTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sel_ctrl_type            ctrl,
   input  logic [CYL_W-1:0]        head,
   input  logic [AW-1:0]           sample_idx,
   input  logic [CYL_W-1:0]        sample_cyl,
   input  logic [NUM_REQUESTS-1:0] served,
   output logic [AW-1:0]           best_idx,
   output logic [CYL_W-1:0]        best_cyl,
   output logic [DIST_W-1:0]       best_dist
);

   logic              found_ff;
   logic [AW-1:0]     best_idx_ff;
   logic [CYL_W-1:0]  best_cyl_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [DIST_W-1:0] seek_dist;
   logic              take;

   // absolute distance and candidate test; strict less keeps lowest slot on a tie
   always_comb begin
      seek_dist = (head > sample_cyl) ? DIST_W'(head - sample_cyl)
                                      : DIST_W'(sample_cyl - head);
      take = ctrl.sample && !served[sample_idx] &&
             (!found_ff || (seek_dist < best_dist_ff));
   end

   // found flag
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   // best candidate payload
   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= sample_idx;
         best_cyl_ff  <= sample_cyl;
         best_dist_ff <= seek_dist;
      end
   end

   assign best_idx  = best_idx_ff;
   assign best_cyl  = best_cyl_ff;
   assign best_dist = best_dist_ff;

endmodule

### rtl/sstf_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// Operation: a load beat stores one request while the store has room. A run over n
//   stored requests takes n steps and can stall on the output; each step streams all n
//   slots out of the request store at one read per cycle, then settles and emits.
// Throughput: one item at a time; the next beat is taken once a run is done.
// Reset: clears the sequencer, request count, served marks and output valid;
//   the request store is not cleared and is only read below the count.
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_unit
// Shortest-seek-first disk scheduler: loads requests, then serves them in
// nearest-first order from a given head position.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_unit
   import sstf_pkg::*;
#(
   parameter int NUM_REQUESTS  = DEF_NUM_REQUESTS,
   parameter int NUM_CYLINDERS = DEF_NUM_CYLINDERS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] cylinder
   input  logic                  req_tuser,   // [0] cmd
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] served_cylinder, [14:12] served_slot,
                                              // [26:15] seek_distance, [42:27] total_movement
   output logic                  rsp_tlast,   // is_last
   output logic                  rsp_tuser    // [0] empty_res
);

   localparam int AW = (NUM_REQUESTS > 1) ? $clog2(NUM_REQUESTS) : 1;
   localparam int CW = $clog2(NUM_REQUESTS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           step_ff;
   logic [CW-1:0]           scan_ff;
   logic [NUM_REQUESTS-1:0] served_ff;
   logic [CYL_W-1:0]        head_ff;
   logic [TOTAL_W-1:0]      total_ff;
   logic [TOTAL_W-1:0]      total_in;
   logic                    rd_vld_ff;
   logic [AW-1:0]           rd_idx_ff;

   logic                    rsp_valid_ff;
   logic [CYL_W-1:0]        rsp_cyl_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [DIST_W-1:0]       rsp_dist_ff;
   logic [TOTAL_W-1:0]      rsp_total_ff;
   logic                    rsp_last_ff;
   logic                    rsp_empty_ff;

   logic                    req_fire;
   logic                    is_run;
   logic [CYL_W-1:0]        cyl_in;
   logic                    out_free;
   logic                    scan_go;
   logic                    emit_go;
   logic                    empty_go;
   logic                    scan_done;
   logic                    last_step;
   logic                    load_wr;
   logic [CYL_W-1:0]        rd_data;
   logic [AW-1:0]           best_idx;
   logic [CYL_W-1:0]        best_cyl;
   logic [DIST_W-1:0]       best_dist;
   logic [TOTAL_W:0]        total_sum;
   sel_ctrl_type            sel_ctrl;

   // input decode and cylinder clamp
   always_comb begin
      req_fire = req_tvalid && req_tready;
      is_run   = (req_tuser == CMD_RUN);
      cyl_in   = (32'(req_tdata[CYL_W-1:0]) > 32'(NUM_CYLINDERS - 1))
                 ? CYL_W'(NUM_CYLINDERS - 1) : req_tdata[CYL_W-1:0];
      load_wr  = req_fire && !is_run && (count_ff < CW'(NUM_REQUESTS));
   end

   // step bookkeeping
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      scan_done = (scan_ff == count_ff) && !rd_vld_ff;
      last_step = ((CW+1)'(step_ff) + (CW+1)'(1)) == (CW+1)'(count_ff);
      total_sum = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(best_dist);
      total_in  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_run) begin
               state_in = (count_ff == '0) ? ST_EMPTY : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_step ? ST_IDLE : ST_SCAN;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      scan_go    = 1'b0;
      emit_go    = 1'b0;
      empty_go   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SCAN:  scan_go    = (scan_ff != count_ff);
         ST_EMIT:  emit_go    = out_free;
         ST_EMPTY: empty_go   = out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // selector control
   always_comb begin
      sel_ctrl.clear  = (req_fire && is_run) || emit_go;
      sel_ctrl.sample = rd_vld_ff;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request count and served marks
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         served_ff <= '0;
      end else if (load_wr) begin
         count_ff <= count_ff + CW'(1);
      end else if (req_fire && is_run) begin
         served_ff <= '0;
      end else if (emit_go) begin
         if (last_step) begin
            count_ff  <= '0;
            served_ff <= '0;
         end else begin
            served_ff[best_idx] <= 1'b1;
         end
      end
   end

   // scan address, step counter and read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         scan_ff   <= '0;
         step_ff   <= '0;
      end else begin
         rd_vld_ff <= scan_go;
         if (req_fire && is_run) begin
            scan_ff <= '0;
            step_ff <= '0;
         end else if (scan_go) begin
            scan_ff <= scan_ff + CW'(1);
         end else if (emit_go) begin
            scan_ff <= '0;
            step_ff <= step_ff + CW'(1);
         end
      end
   end

   // head position, running total and read index
   always_ff @(posedge clock) begin
      if (req_fire && is_run) begin
         head_ff  <= cyl_in;
         total_ff <= '0;
      end else if (emit_go) begin
         head_ff  <= best_cyl;
         total_ff <= total_in;
      end
      if (scan_go) begin
         rd_idx_ff <= scan_ff[AW-1:0];
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go || empty_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_cyl_ff   <= best_cyl;
         rsp_slot_ff  <= SLOT_W'(best_idx);
         rsp_dist_ff  <= best_dist;
         rsp_total_ff <= total_in;
         rsp_last_ff  <= last_step;
         rsp_empty_ff <= 1'b0;
      end else if (empty_go) begin
         rsp_cyl_ff   <= '0;
         rsp_slot_ff  <= '0;
         rsp_dist_ff  <= '0;
         rsp_total_ff <= '0;
         rsp_last_ff  <= 1'b0;
         rsp_empty_ff <= 1'b1;
      end
   end

   // request store
   sstf_store #(
      .NUM_REQUESTS (NUM_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cyl_in),
      .rd_en   (scan_go),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // nearest request tracker
   sstf_select #(
      .NUM_REQUESTS (NUM_REQUESTS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sel_ctrl),
      .head       (head_ff),
      .sample_idx (rd_idx_ff),
      .sample_cyl (rd_data),
      .served     (served_ff),
      .best_idx   (best_idx),
      .best_cyl   (best_cyl),
      .best_dist  (best_dist)
   );

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_total_ff, rsp_dist_ff, rsp_slot_ff, rsp_cyl_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule
